// File: rtl/egd_pkg.sv
// Shared types and constants for the Exp-Golomb bit decoder.
package egd_pkg;

   // Field widths
   localparam int BYTE_W  = 8;
   localparam int VALUE_W = 32;
   localparam int ZC_W    = 6;   // holds a prefix run of up to 33 zeros
   localparam int IDX_W   = 3;   // bit position within a byte

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_PREFIX = 2'd1,
      STATUS_TRUNC  = 2'd2
   } status_type;

   // One queued input item
   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              final_byte;
   } item_type;

   // Head of the input queue as seen by the bit engine
   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   // One decoded result
   typedef struct packed {
      logic [VALUE_W-1:0] code_value;
      status_type         status;
   } result_type;

endpackage

// File: rtl/egd_front.sv
// Input side: accepts bytes into a two-entry queue ahead of the bit engine.
module egd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  egd_pkg::item_type req_item,
   output egd_pkg::head_type head,
   input  logic              pop
);

   logic [1:0]        count_ff, count_in;
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   egd_pkg::item_type store_ff [2];
   logic              push;

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;

   // Queue head towards the engine
   assign head.valid = (count_ff != 2'd0);
   assign head.item  = store_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= req_item;
      end
   end

endmodule

// File: rtl/egd_back.sv
// Bit engine: bytes MSB first, one bit a cycle unless rsp stalls; emits results.
module egd_back #(
   parameter int MAX_ZEROS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  egd_pkg::head_type           head,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [egd_pkg::VALUE_W-1:0] rsp_code_value,
   output logic [1:0]                  rsp_status,
   output logic                        rsp_run_last
);

   // Decode state
   logic                        in_suffix_ff, in_suffix_in;
   logic [egd_pkg::ZC_W-1:0]    zero_count_ff, zero_count_in;
   logic [egd_pkg::ZC_W-1:0]    suffix_left_ff, suffix_left_in;
   logic [egd_pkg::VALUE_W-1:0] acc_ff, acc_in;
   logic [egd_pkg::IDX_W-1:0]   bit_idx_ff, bit_idx_in;

   // Pending result, held until it is known whether it closes its byte
   logic                        pend_valid_ff, pend_valid_in;
   logic                        pend_final_ff, pend_final_in;
   egd_pkg::result_type         pend_ff, pend_in;

   // Output register
   logic                        out_valid_ff, out_valid_in;
   egd_pkg::result_type         out_ff, out_in;
   logic                        out_last_ff, out_last_in;

   logic                        cur_bit;
   logic                        out_free;
   logic                        step;
   logic                        byte_end;
   logic                        r_valid;
   egd_pkg::result_type         r_res;
   logic [egd_pkg::ZC_W-1:0]    zc_inc;
   logic [egd_pkg::ZC_W-1:0]    sl_dec;
   logic [egd_pkg::VALUE_W-1:0] acc_shift;
   logic                        do_push;
   logic                        push_last;

   assign cur_bit  = head.item.data_byte[bit_idx_ff];
   assign out_free = !out_valid_ff || rsp_ready;
   assign step     = head.valid && out_free;
   assign byte_end = (bit_idx_ff == '0);
   assign pop      = step && byte_end;

   assign zc_inc    = zero_count_ff + egd_pkg::ZC_W'(1);
   assign sl_dec    = suffix_left_ff - egd_pkg::ZC_W'(1);
   assign acc_shift = {acc_ff[egd_pkg::VALUE_W-2:0], cur_bit};

   // One bit of decoding, plus the truncation check at the end of a final byte
   always_comb begin
      in_suffix_in   = in_suffix_ff;
      zero_count_in  = zero_count_ff;
      suffix_left_in = suffix_left_ff;
      acc_in         = acc_ff;
      r_valid        = 1'b0;
      r_res.code_value = '0;
      r_res.status     = egd_pkg::STATUS_OK;

      if (step) begin
         if (!in_suffix_ff) begin
            if (!cur_bit) begin
               if (zc_inc > egd_pkg::ZC_W'(MAX_ZEROS)) begin
                  r_valid       = 1'b1;
                  r_res.status  = egd_pkg::STATUS_PREFIX;
                  zero_count_in = '0;
               end else begin
                  zero_count_in = zc_inc;
               end
            end else if (zero_count_ff == '0) begin
               r_valid = 1'b1;
            end else begin
               in_suffix_in   = 1'b1;
               suffix_left_in = zero_count_ff;
               acc_in         = egd_pkg::VALUE_W'(1);
            end
         end else begin
            acc_in = acc_shift;
            if (sl_dec == '0) begin
               r_valid          = 1'b1;
               r_res.code_value = acc_shift - egd_pkg::VALUE_W'(1);
               in_suffix_in     = 1'b0;
               zero_count_in    = '0;
               suffix_left_in   = '0;
               acc_in           = egd_pkg::VALUE_W'(1);
            end else begin
               suffix_left_in = sl_dec;
            end
         end

         // Data ends mid code: report truncation and start afresh
         if (byte_end && head.item.final_byte) begin
            if (!r_valid && (in_suffix_in || zero_count_in != '0)) begin
               r_valid      = 1'b1;
               r_res.status = egd_pkg::STATUS_TRUNC;
            end
            in_suffix_in   = 1'b0;
            zero_count_in  = '0;
            suffix_left_in = '0;
            acc_in         = egd_pkg::VALUE_W'(1);
         end
      end
   end

   assign bit_idx_in = step ? bit_idx_ff - egd_pkg::IDX_W'(1) : bit_idx_ff;

   // Pending slot: released once a later result or the byte end settles run_last
   assign do_push   = out_free && pend_valid_ff &&
                      (pend_final_ff || (step && (r_valid || byte_end)));
   assign push_last = pend_final_ff || (step && byte_end && !r_valid);

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_final_in = pend_final_ff;
      pend_in       = pend_ff;
      if (step && r_valid) begin
         pend_valid_in = 1'b1;
         pend_final_in = byte_end;
         pend_in       = r_res;
      end else if (do_push) begin
         pend_valid_in = 1'b0;
         pend_final_in = 1'b0;
      end
   end

   // Output register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      out_last_in  = out_last_ff;
      if (do_push) begin
         out_valid_in = 1'b1;
         out_in       = pend_ff;
         out_last_in  = push_last;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_suffix_ff   <= 1'b0;
         zero_count_ff  <= '0;
         suffix_left_ff <= '0;
         acc_ff         <= egd_pkg::VALUE_W'(1);
         bit_idx_ff     <= '1;
         pend_valid_ff  <= 1'b0;
         pend_final_ff  <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         in_suffix_ff   <= in_suffix_in;
         zero_count_ff  <= zero_count_in;
         suffix_left_ff <= suffix_left_in;
         acc_ff         <= acc_in;
         bit_idx_ff     <= bit_idx_in;
         pend_valid_ff  <= pend_valid_in;
         pend_final_ff  <= pend_final_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_code_value = out_ff.code_value;
   assign rsp_status     = out_ff.status;
   assign rsp_run_last   = out_last_ff;

endmodule

// File: rtl/exp_golomb_bit_decoder.sv
// Top level of the order-0 unsigned Exp-Golomb decoder over a byte stream.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | data_byte[7:0], final_byte
//   rsp     | out       | rsp_valid/rsp_ready  | code_value[31:0], status[1:0], run_last
//
// The bit engine reads one bit a cycle while a byte is queued and rsp can take
// results, so each byte yields 0 to 8 results. A result waits in a pending slot
// until its run_last flag is known, then moves on to the output register.
// The two-entry input queue takes bytes while results wait at rsp, until it is full.
// Reset is synchronous and returns the decoder to the start of a prefix.
module exp_golomb_bit_decoder #(
   parameter int MAX_ZEROS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_final_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_code_value,
   output logic [1:0]  rsp_status,
   output logic        rsp_run_last
);

   egd_pkg::item_type req_item;
   egd_pkg::head_type head;
   logic              pop;

   assign req_item.data_byte  = req_data_byte;
   assign req_item.final_byte = req_final_byte;

   egd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .head      (head),
      .pop       (pop)
   );

   egd_back #(
      .MAX_ZEROS (MAX_ZEROS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_code_value (rsp_code_value),
      .rsp_status     (rsp_status),
      .rsp_run_last   (rsp_run_last)
   );

endmodule

// File: rtl/egd_checker.sv
// Port-level assertions for the Exp-Golomb decoder, bound to the top level.
module egd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_code_value,
   input logic [1:0]  rsp_status,
   input logic        rsp_run_last
);

   // Nothing is offered straight after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered after reset");

   // Error results carry a zero value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != egd_pkg::STATUS_OK) |-> (rsp_code_value == 32'd0))
      else $error("error result with non-zero value");

   // Only the three defined status codes appear
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == egd_pkg::STATUS_OK ||
                     rsp_status == egd_pkg::STATUS_PREFIX ||
                     rsp_status == egd_pkg::STATUS_TRUNC))
      else $error("undefined status code");

   // Truncation always closes the results of its byte
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == egd_pkg::STATUS_TRUNC) |-> rsp_run_last)
      else $error("truncation result not marked last");

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_code_value) && $stable(rsp_status) &&
          $stable(rsp_run_last)))
      else $error("stalled result changed");

endmodule

bind exp_golomb_bit_decoder egd_checker u_egd_checker (.*);

// File: tb/testbench.sv
// Self-checking testbench for the order-0 Exp-Golomb byte-stream decoder.
`timescale 1ns / 1ps

module testbench;

   localparam int MAX_ZEROS    = 32;
   localparam int ITEMS        = 330;
   localparam int QUIET_ITEMS  = 60;      // no idling over the last stretch
   localparam int DRAIN_CYCLES = 48;      // two queued bytes plus result slots
   localparam int CYCLE_LIMIT  = 400000;

   // One expected decoder result
   typedef struct packed {
      logic [31:0]         value;
      egd_pkg::status_type status;
      logic                run_last;
   } code_result;

   // Predicts decoded codes from accepted bytes and checks them in order
   class golomb_scoreboard;
      bit          in_suffix   = 1'b0;
      bit [5:0]    zero_count  = '0;
      bit [5:0]    suffix_left = '0;
      bit [31:0]   acc         = 32'd1;
      code_result  pending[$];
      int          mismatches  = 0;
      int          checked     = 0;
      int          n_prefix    = 0;
      int          n_trunc     = 0;

      function void restart_code();
         in_suffix   = 1'b0;
         zero_count  = '0;
         suffix_left = '0;
         acc         = 32'd1;
      endfunction

      function void add_result(logic [31:0] value, egd_pkg::status_type status);
         code_result r;
         r.value    = value;
         r.status   = status;
         r.run_last = 1'b0;
         pending.push_back(r);
      endfunction

      // Walk the byte MSB first and queue every result it yields, error results included
      function void note_item(logic [7:0] data, logic fin);
         int first;
         bit b;
         first = pending.size();
         for (int i = 7; i >= 0; i--) begin
            b = data[i];
            if (!in_suffix) begin
               if (!b) begin
                  zero_count = zero_count + 6'd1;
                  if (zero_count > MAX_ZEROS) begin
                     add_result('0, egd_pkg::STATUS_PREFIX);
                     restart_code();
                  end
               end else if (zero_count == 0) begin
                  add_result('0, egd_pkg::STATUS_OK);
                  restart_code();
               end else begin
                  in_suffix   = 1'b1;
                  suffix_left = zero_count;
                  acc         = 32'd1;
               end
            end else begin
               acc         = {acc[30:0], b};
               suffix_left = suffix_left - 6'd1;
               if (suffix_left == 0) begin
                  add_result(acc - 32'd1, egd_pkg::STATUS_OK);
                  restart_code();
               end
            end
         end
         // end of buffer: a half-read code is reported as truncated
         if (fin) begin
            if (in_suffix || zero_count != 0)
               add_result('0, egd_pkg::STATUS_TRUNC);
            restart_code();
         end
         if (pending.size() > first)
            pending[pending.size()-1].run_last = 1'b1;
      endfunction

      function void check_result(logic [31:0] value, logic [1:0] status, logic run_last);
         code_result want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result, value %h status %0d run_last %b",
                     $time, value, status, run_last);
            mismatches++;
            return;
         end
         want = pending.pop_front();
         checked++;
         if (want.status == egd_pkg::STATUS_PREFIX) n_prefix++;
         if (want.status == egd_pkg::STATUS_TRUNC) n_trunc++;
         if (value !== want.value) begin
            $display("%0t: code_value mismatch, expected %h, actual %h",
                     $time, want.value, value);
            mismatches++;
         end
         if (status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, status);
            mismatches++;
         end
         if (run_last !== want.run_last) begin
            $display("%0t: run_last mismatch, expected %b, actual %b",
                     $time, want.run_last, run_last);
            mismatches++;
         end
      endfunction
   endclass

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte  = '0;
   logic        req_final_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready      = 1'b0;
   logic [31:0] rsp_code_value;
   logic [1:0]  rsp_status;
   logic        rsp_run_last;

   golomb_scoreboard sb;
   int items_sent  = 0;
   int cycles      = 0;
   int stall_left  = 0;
   bit quiet_tail  = 1'b0;

   exp_golomb_bit_decoder #(.MAX_ZEROS(MAX_ZEROS)) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_code_value (rsp_code_value),
      .rsp_status     (rsp_status),
      .rsp_run_last   (rsp_run_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, sb.pending.size());
         $display("Verification failed");
         $finish;
      end
   end

   // Result side: check accepted items, stall in random bursts
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_code_value, rsp_status, rsp_run_last);
      if (stall_left != 0)
         stall_left--;
      else if (!quiet_tail && $urandom_range(0, 5) == 0)
         stall_left = $urandom_range(1, 15);
      rsp_ready <= (stall_left == 0);
   end

   // Offer one byte, with an optional idle burst before it
   task automatic send_byte(input logic [7:0] data, input logic fin);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_data_byte  <= data;
      req_final_byte <= fin;
      do @(posedge clock); while (!req_ready);
      sb.note_item(data, fin);
      items_sent++;
      quiet_tail = (items_sent >= ITEMS - QUIET_ITEMS);
   endtask

   // Build a run of codes as a bit string, then send it byte by byte
   task automatic send_random_stream();
      bit   bits[$];
      int   n, sel, mode, cut;
      bit   fill, end_buf;
      logic [7:0] data;
      repeat ($urandom_range(1, 12)) begin
         sel = $urandom_range(0, 99);
         if (sel < 5) begin
            // overlong prefix
            repeat ($urandom_range(MAX_ZEROS + 1, MAX_ZEROS + 8)) bits.push_back(1'b0);
         end else begin
            if (sel < 9)       n = MAX_ZEROS;
            else if (sel < 20) n = $urandom_range(7, MAX_ZEROS - 1);
            else               n = $urandom_range(0, 6);
            repeat (n) bits.push_back(1'b0);
            bits.push_back(1'b1);
            repeat (n) bits.push_back(1'($urandom_range(0, 1)));
         end
      end
      mode = $urandom_range(0, 9);
      // cut the tail off so the buffer ends mid code
      if (mode == 7 && bits.size() > 1) begin
         cut = $urandom_range(1, (bits.size() > 25) ? 24 : bits.size() - 1);
         repeat (cut) void'(bits.pop_back());
      end
      fill    = (mode <= 6 || mode == 9);
      end_buf = (mode <= 5 || mode == 7);
      while (bits.size() % 8 != 0) bits.push_back(fill);
      for (int i = 0; i < bits.size(); i += 8) begin
         for (int k = 0; k < 8; k++)
            data[7-k] = bits[i+k];
         send_byte(data, end_buf && (i + 8 == bits.size()));
      end
      // one to three raw bytes
      if (mode == 9)
         repeat ($urandom_range(1, 3))
            send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endtask

   // {final_byte, data_byte}
   logic [8:0] directed_seq[$] = '{
      // 32 zeros, one, 32 suffix zeros: wraps to all ones, then seven zero values
      9'h000, 9'h000, 9'h000, 9'h000, 9'h080, 9'h000, 9'h000, 9'h000, 9'h07F,
      // 32 zeros, one, 32 suffix ones, then an overlong prefix and a cut-off prefix
      9'h000, 9'h000, 9'h000, 9'h000, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h080,
      9'h000, 9'h000, 9'h000, 9'h100,
      // value three, then the buffer ends inside a prefix
      9'h120,
      // buffer ends inside a suffix
      9'h103,
      // eight value-zero codes and a clean end
      9'h1FF
   };

   initial begin
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_seq[i])
         send_byte(directed_seq[i][7:0], directed_seq[i][8]);
      while (items_sent < ITEMS)
         send_random_stream();
      req_valid <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d bytes; checked %0d decoded codes.", items_sent, sb.checked);
      $display("Of those, %0d were prefix overruns and %0d truncations.",
               sb.n_prefix, sb.n_trunc);
      if (sb.mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
